// ----- rtl/mfva_pkg.sv -----
`default_nettype none

package mfva_pkg;

  localparam int unsigned VoicesDef = 16;
  localparam int unsigned SrW       = 18;
  localparam int unsigned HzW       = 24;
  localparam int unsigned DivW      = 34;
  localparam int unsigned DivSteps  = DivW;
  localparam int unsigned DivCntW   = $clog2(DivSteps + 1);
  localparam int unsigned ApbAddrW  = 3;
  localparam int unsigned ApbDataW  = 32;

  localparam logic [3:0]     StatusNoteOff  = 4'h8;
  localparam logic [3:0]     StatusNoteOn   = 4'h9;
  localparam logic [3:0]     StatusCtrl     = 4'hB;
  localparam logic [6:0]     CcAllSoundOff  = 7'd120;
  localparam logic [6:0]     CcAllNotesOff  = 7'd123;
  localparam logic [7:0]     RegFreqLo      = 8'hA0;
  localparam logic [7:0]     RegKeyOn       = 8'hB0;
  localparam logic [7:0]     KeyOnBit       = 8'h20;
  localparam logic [4:0]     ChansPerBank   = 5'd9;
  localparam logic [15:0]    Recip12        = 16'd171;
  localparam logic [SrW-1:0] SampleRateRst  = 18'd44100;
  localparam logic [0:0]     RegSampleRate  = 1'b0;

  typedef struct packed {
    logic [7:0] status_byte;
    logic [6:0] data_one;
    logic [6:0] data_two;
  } in_item_t;

  typedef struct packed {
    logic [8:0] reg_address;
    logic [7:0] reg_data;
    logic       last_write;
  } out_item_t;

  typedef enum logic [7:0] {
    StIdle = 8'b0000_0001,
    StScan = 8'b0000_0010,
    StPrep = 8'b0000_0100,
    StLoad = 8'b0000_1000,
    StDiv  = 8'b0001_0000,
    StFlo  = 8'b0010_0000,
    StKey  = 8'b0100_0000,
    StRel  = 8'b1000_0000
  } state_e;

  function automatic logic [31:0] top_octave(input logic [3:0] semi);
    logic [31:0] val;
    case (semi)
      4'd0:    val = 32'd435478539;
      4'd1:    val = 32'd461373440;
      4'd2:    val = 32'd488808132;
      4'd3:    val = 32'd517874176;
      4'd4:    val = 32'd548668578;
      4'd5:    val = 32'd581294109;
      4'd6:    val = 32'd615859655;
      4'd7:    val = 32'd652480576;
      4'd8:    val = 32'd691279090;
      4'd9:    val = 32'd732384684;
      4'd10:   val = 32'd775934544;
      4'd11:   val = 32'd822074013;
      default: val = 32'd0;
    endcase
    return val;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/midi_fm_voice_allocator_unit.sv -----
`default_nettype none

// A note-on scans the voices one by one and, if a voice is free, passes the prepare and
// load states, runs the bit-serial restoring divider, then issues its two transfers.
// A release scans the voices, then walks them again and writes a key-off for each match.
// One message at a time: in_ready_o is high only in the idle state.
// Reset: all voices inactive, sample rate 44100, output empty; no clearing pass.
module midi_fm_voice_allocator_unit
  import mfva_pkg::*;
#(
  parameter int unsigned VOICES = VoicesDef
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_ready_o,
  input  wire  in_item_t      in_data_i,
  output logic                out_valid_o,
  input  wire                 out_ready_i,
  output out_item_t           out_data_o,
  input  wire                 psel,
  input  wire                 penable,
  input  wire                 pwrite,
  input  wire  [ApbAddrW-1:0] paddr,
  input  wire  [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready
);

  localparam int unsigned VIdxW = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam logic [VIdxW-1:0] LastVoice = VIdxW'(VOICES - 1);

  state_e            state_q;
  logic [SrW-1:0]    sample_rate_q;
  logic [VOICES-1:0] voice_active_q;
  logic [6:0]        voice_note_q [VOICES];
  logic [VOICES-1:0] mask_q;
  logic [VIdxW-1:0]  cnt_q;
  logic [VIdxW-1:0]  free_q;
  logic              found_q;
  logic              is_on_q;
  logic              all_q;
  logic [6:0]        note_q;
  logic [3:0]        oct_n_q;
  logic [3:0]        oct_t_q;
  logic [2:0]        blk_q;
  logic [DivW-1:0]   num_q;
  logic [SrW-1:0]    rem_q;
  logic [DivCntW-1:0] div_cnt_q;
  logic              out_valid_q;
  out_item_t         out_data_q;

  logic              accept;
  logic              out_free;
  logic              cfg_write;
  logic              hit_rel;
  logic              hit_free;
  logic [VOICES-1:0] mask_rest;
  logic [7:0]        t_note;
  logic [15:0]       prod_n;
  logic [15:0]       prod_t;
  logic [3:0]        semi;
  logic [4:0]        shamt;
  logic [31:0]       hz_sum;
  logic [HzW-1:0]    hz;
  logic [2:0]        blk;
  logic [3:0]        oct_m1;
  logic [DivW-1:0]   num_init;
  logic [SrW:0]      trial;
  logic              qbit;
  logic [7:0]        key_data;

  function automatic logic [8:0] voice_addr(input logic [VIdxW-1:0] v,
                                            input logic [7:0] base);
    logic [4:0] vx;
    logic       bank;
    logic [4:0] ch;
    vx   = 5'(v);
    bank = (vx >= ChansPerBank);
    ch   = bank ? (vx - ChansPerBank) : vx;
    return {bank, 8'(base + {3'b000, ch})};
  endfunction

  assign in_ready_o  = (state_q == StIdle);
  assign accept      = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && (paddr[2] == RegSampleRate);
  assign prdata    = (paddr[2] == RegSampleRate) ? ApbDataW'(sample_rate_q) : '0;

  assign hit_rel   = voice_active_q[cnt_q] && (all_q || (voice_note_q[cnt_q] == note_q));
  assign hit_free  = !voice_active_q[cnt_q];
  assign mask_rest = mask_q & ~(VOICES'(1) << cnt_q);

  assign t_note = 8'(note_q) + 8'd4;
  assign prod_n = 16'(note_q) * Recip12;
  assign prod_t = 16'(t_note) * Recip12;

  assign semi     = 4'(t_note - 8'(oct_t_q) * 8'd12);
  assign shamt    = 5'd16 - 5'(oct_t_q);
  assign hz_sum   = top_octave(semi) + (32'd1 << (shamt - 5'd1));
  assign hz       = HzW'(hz_sum >> shamt);
  assign oct_m1   = oct_n_q - 4'd1;
  assign blk      = (oct_n_q == 4'd0) ? 3'd0 : ((oct_m1 > 4'd7) ? 3'd7 : oct_m1[2:0]);
  assign num_init = DivW'(hz) << (4'd10 - {1'b0, blk});

  assign trial = {rem_q, num_q[DivW-1]};
  assign qbit  = (trial >= {1'b0, sample_rate_q});

  assign key_data = KeyOnBit | {3'b000, blk_q, 2'b00} | {6'b000000, num_q[9:8]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_rate_q <= SampleRateRst;
    end else if (cfg_write) begin
      sample_rate_q <= pwdata[SrW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StPrep) begin
      voice_note_q[free_q] <= note_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      note_q <= in_data_i.data_one;
    end
    if (state_q == StPrep) begin
      oct_n_q <= prod_n[14:11];
      oct_t_q <= prod_t[14:11];
    end
    if (state_q == StLoad) begin
      blk_q <= blk;
      num_q <= num_init;
      rem_q <= '0;
    end else if (state_q == StDiv) begin
      num_q <= {num_q[DivW-2:0], qbit};
      rem_q <= qbit ? SrW'(trial - {1'b0, sample_rate_q}) : SrW'(trial);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= StIdle;
      voice_active_q <= '0;
      mask_q         <= '0;
      cnt_q          <= '0;
      free_q         <= '0;
      found_q        <= 1'b0;
      is_on_q        <= 1'b0;
      all_q          <= 1'b0;
      div_cnt_q      <= '0;
      out_valid_q    <= 1'b0;
      out_data_q     <= '0;
    end else begin
      if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        StIdle: begin
          cnt_q   <= '0;
          found_q <= 1'b0;
          mask_q  <= '0;
          if (accept) begin
            if (in_data_i.status_byte[7:4] == StatusNoteOn && in_data_i.data_two != 7'd0) begin
              is_on_q <= 1'b1;
              all_q   <= 1'b0;
              state_q <= StScan;
            end else if (in_data_i.status_byte[7:4] == StatusNoteOn ||
                         in_data_i.status_byte[7:4] == StatusNoteOff) begin
              is_on_q <= 1'b0;
              all_q   <= 1'b0;
              state_q <= StScan;
            end else if (in_data_i.status_byte[7:4] == StatusCtrl &&
                         (in_data_i.data_one == CcAllSoundOff ||
                          in_data_i.data_one == CcAllNotesOff)) begin
              is_on_q <= 1'b0;
              all_q   <= 1'b1;
              state_q <= StScan;
            end
          end
        end
        StScan: begin
          mask_q[cnt_q] <= hit_rel;
          if (is_on_q && hit_free && !found_q) begin
            found_q <= 1'b1;
            free_q  <= cnt_q;
          end
          if (cnt_q == LastVoice) begin
            cnt_q <= '0;
            if (is_on_q) begin
              state_q <= (found_q || hit_free) ? StPrep : StIdle;
            end else begin
              state_q <= (mask_q != '0 || hit_rel) ? StRel : StIdle;
            end
          end else begin
            cnt_q <= cnt_q + VIdxW'(1);
          end
        end
        StPrep: begin
          voice_active_q[free_q] <= 1'b1;
          state_q                <= StLoad;
        end
        StLoad: begin
          div_cnt_q <= DivCntW'(DivSteps);
          state_q   <= StDiv;
        end
        StDiv: begin
          div_cnt_q <= div_cnt_q - DivCntW'(1);
          if (div_cnt_q == DivCntW'(1)) begin
            state_q <= StFlo;
          end
        end
        StFlo: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_data_q  <= '{reg_address: voice_addr(free_q, RegFreqLo),
                             reg_data:    num_q[7:0],
                             last_write:  1'b0};
            state_q     <= StKey;
          end
        end
        StKey: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_data_q  <= '{reg_address: voice_addr(free_q, RegKeyOn),
                             reg_data:    key_data,
                             last_write:  1'b1};
            state_q     <= StIdle;
          end
        end
        StRel: begin
          if (!mask_q[cnt_q]) begin
            cnt_q <= cnt_q + VIdxW'(1);
          end else if (out_free) begin
            out_valid_q           <= 1'b1;
            out_data_q            <= '{reg_address: voice_addr(cnt_q, RegKeyOn),
                                       reg_data:    8'h00,
                                       last_write:  (mask_rest == '0)};
            voice_active_q[cnt_q] <= 1'b0;
            mask_q[cnt_q]         <= 1'b0;
            if (mask_rest == '0) begin
              state_q <= StIdle;
            end else begin
              cnt_q <= cnt_q + VIdxW'(1);
            end
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
  import mfva_pkg::*;

  localparam int unsigned NumVoices = VoicesDef;
  localparam int unsigned DrainCycles = 100;
  localparam logic [ApbAddrW-1:0] SampleRateAddr = {RegSampleRate, 2'b00};

  localparam logic [31:0] OctaveQ16 [12] = '{
    32'd435478539, 32'd461373440, 32'd488808132, 32'd517874176,
    32'd548668578, 32'd581294109, 32'd615859655, 32'd652480576,
    32'd691279090, 32'd732384684, 32'd775934544, 32'd822074013
  };

  class voice_scoreboard;
    bit              voice_on [NumVoices];
    logic [6:0]      voice_pitch [NumVoices];
    logic [SrW-1:0]  sample_rate;
    out_item_t       expected_writes [$];
    int              fails;

    function new();
      foreach (voice_on[v]) begin
        voice_on[v] = 1'b0;
        voice_pitch[v] = '0;
      end
      sample_rate = SampleRateRst;
      fails = 0;
    endfunction

    function automatic logic [8:0] voice_reg(int v, logic [7:0] base);
      logic [7:0] low;
      low = base + 8'(v % int'(ChansPerBank));
      return {(v >= int'(ChansPerBank)) ? 1'b1 : 1'b0, low};
    endfunction

    function automatic logic [9:0] freq_number(logic [6:0] note, logic [2:0] blk);
      int unsigned t;
      int unsigned sh;
      longint unsigned hz;
      longint unsigned num;
      t = int'(note) + 4;
      sh = 6 + (10 - t / 12);
      hz = (longint'(OctaveQ16[t % 12]) + (64'd1 << (sh - 1))) >> sh;
      num = hz << (10 - blk);
      if (sample_rate == '0) return 10'h3FF;
      return 10'(num / longint'(sample_rate));
    endfunction

    function void take_message(in_item_t msg);
      out_item_t batch [$];
      out_item_t w;
      bit all;
      bit rel;
      int unsigned oct;
      logic [2:0] blk;
      logic [9:0] fnum;
      all = 1'b0;
      rel = 1'b0;
      if (msg.status_byte[7:4] == StatusNoteOn && msg.data_two != '0) begin
        for (int v = 0; v < NumVoices; v++) begin
          if (!voice_on[v]) begin
            oct = msg.data_one / 12;
            blk = (oct == 0) ? 3'd0 : (oct - 1 > 7) ? 3'd7 : 3'(oct - 1);
            fnum = freq_number(msg.data_one, blk);
            voice_on[v] = 1'b1;
            voice_pitch[v] = msg.data_one;
            w.reg_address = voice_reg(v, RegFreqLo);
            w.reg_data = fnum[7:0];
            w.last_write = 1'b0;
            batch.push_back(w);
            w.reg_address = voice_reg(v, RegKeyOn);
            w.reg_data = KeyOnBit | {3'b000, blk, fnum[9:8]};
            batch.push_back(w);
            break;
          end
        end
      end else if (msg.status_byte[7:4] == StatusNoteOn
                   || msg.status_byte[7:4] == StatusNoteOff) begin
        rel = 1'b1;
      end else if (msg.status_byte[7:4] == StatusCtrl
                   && (msg.data_one == CcAllSoundOff || msg.data_one == CcAllNotesOff)) begin
        rel = 1'b1;
        all = 1'b1;
      end
      if (rel) begin
        for (int v = 0; v < NumVoices; v++) begin
          if (voice_on[v] && (all || voice_pitch[v] == msg.data_one)) begin
            w.reg_address = voice_reg(v, RegKeyOn);
            w.reg_data = '0;
            w.last_write = 1'b0;
            batch.push_back(w);
            voice_on[v] = 1'b0;
          end
        end
      end
      if (batch.size() > 0) batch[batch.size() - 1].last_write = 1'b1;
      foreach (batch[i]) expected_writes.push_back(batch[i]);
    endfunction

    function void compare(string field, int unsigned want, int unsigned got);
      if (want != got) begin
        $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
        fails++;
      end
    endfunction

    function void check_write(out_item_t got);
      out_item_t want;
      if (expected_writes.size() == 0) begin
        $display("%0t: unexpected register write, expected none, actual 0x%0h <= 0x%0h",
                 $time, got.reg_address, got.reg_data);
        fails++;
        return;
      end
      want = expected_writes.pop_front();
      compare("reg_address", want.reg_address, got.reg_address);
      compare("reg_data", want.reg_data, got.reg_data);
      compare("last_write", want.last_write, got.last_write);
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready_o;
  in_item_t            in_data = '0;
  logic                out_valid_o;
  logic                out_ready = 1'b0;
  out_item_t           out_data_o;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [ApbAddrW-1:0] paddr = '0;
  logic [ApbDataW-1:0] pwdata = '0;
  logic [ApbDataW-1:0] prdata;
  logic                pready;

  bit                  gaps_on = 1'b1;
  voice_scoreboard     sb;

  midi_fm_voice_allocator_unit u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready),
    .out_data_o (out_data_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always #2 clk_i = ~clk_i;

  initial begin
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready) sb.check_write(out_data_o);
      out_ready <= gaps_on ? ($urandom_range(99) >= 26) : 1'b1;
    end
  end

  function automatic in_item_t make_msg(logic [3:0] kind, logic [6:0] d1, logic [6:0] d2);
    in_item_t m;
    m.status_byte = {kind, 4'($urandom_range(15))};
    m.data_one = d1;
    m.data_two = d2;
    return m;
  endfunction

  task automatic apb_access(input bit wr, input logic [SrW-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= SampleRateAddr;
    pwdata <= ApbDataW'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (!wr && prdata != ApbDataW'(value)) begin
      $display("%0t: sample_rate_hz readback mismatch, expected 0x%0h, actual 0x%0h",
               $time, value, prdata);
      sb.fails++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_sample_rate(input logic [SrW-1:0] value);
    apb_access(1'b1, value);
    sb.sample_rate = value;
    apb_access(1'b0, value);
  endtask

  task automatic send_message(input in_item_t msg);
    if (gaps_on && $urandom_range(99) < 26) begin
      in_valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < 26);
    end
    in_valid <= 1'b1;
    in_data <= msg;
    do @(posedge clk_i); while (!in_ready_o);
    sb.take_message(msg);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.expected_writes.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic run_random_messages(input int count);
    logic [6:0] held [$];
    logic [6:0] note;
    in_item_t   msg;
    int         r;
    for (int i = 0; i < count; i++) begin
      held.delete();
      foreach (sb.voice_on[v]) if (sb.voice_on[v]) held.push_back(sb.voice_pitch[v]);
      r = $urandom_range(99);
      note = 7'($urandom_range(127));
      if (r < 50) begin
        if (r < 10 && held.size() > 0) note = held[$urandom_range(held.size() - 1)];
        msg = make_msg(StatusNoteOn, note, 7'($urandom_range(127, 1)));
      end else if (r < 75) begin
        if (held.size() > 0 && r < 72) note = held[$urandom_range(held.size() - 1)];
        if (r < 69) msg = make_msg(StatusNoteOff, note, 7'($urandom_range(127)));
        else msg = make_msg(StatusNoteOn, note, 7'd0);
      end else if (r < 80) begin
        msg = make_msg(StatusCtrl, (r < 78) ? CcAllNotesOff : CcAllSoundOff,
                       7'($urandom_range(127)));
      end else begin
        msg.status_byte = 8'($urandom_range(255));
        msg.data_one = 7'($urandom_range(127));
        msg.data_two = 7'($urandom_range(127));
      end
      send_message(msg);
    end
  endtask

  initial begin
    logic [SrW-1:0] rates [7];
    sb = new();
    rates = '{18'd1000, 18'd192000, 18'd0, 18'h3FFFF, 18'd44100, 18'd1, 18'd48000};
    rates[4] = SrW'($urandom_range(192000, 1000));
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_message(make_msg(StatusNoteOn, 7'd0, 7'd127));
    send_message(make_msg(StatusNoteOn, 7'd127, 7'd1));
    send_message(make_msg(StatusNoteOn, 7'd23, 7'd64));
    send_message(make_msg(StatusNoteOn, 7'd60, 7'd100));
    send_message(make_msg(StatusNoteOn, 7'd60, 7'd100));
    send_message(make_msg(StatusNoteOn, 7'd108, 7'd42));
    send_message(make_msg(StatusNoteOff, 7'd60, 7'd0));
    send_message(make_msg(StatusNoteOn, 7'd127, 7'd0));
    send_message(make_msg(StatusNoteOff, 7'd99, 7'd127));
    send_message(make_msg(StatusCtrl, 7'd121, 7'd0));
    send_message(make_msg(4'hE, 7'd127, 7'd127));
    send_message(make_msg(4'hF, 7'd0, 7'd0));
    send_message(make_msg(StatusCtrl, CcAllSoundOff, 7'd0));
    for (int i = 0; i <= NumVoices; i++)
      send_message(make_msg(StatusNoteOn, 7'(12 + i * 7), 7'(1 + i * 7)));
    send_message(make_msg(StatusCtrl, CcAllNotesOff, 7'd127));
    drain();

    foreach (rates[p]) begin
      set_sample_rate(rates[p]);
      gaps_on = (p != 3);
      run_random_messages(17);
      drain();
    end

    if (sb.fails == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/mfva_pkg.sv
rtl/midi_fm_voice_allocator_unit.sv
tb/sv/tb_top.sv
